// ===== sv/ir_pdt_pkg.sv =====
// ir_pdt_pkg: shared types, register indexes and reset values for the
// pulse-distance infrared transmitter. No dependencies.

package ir_pdt_pkg;

   localparam int CODE_BITS_DEF     = 32;
   localparam int DURATION_BITS_DEF = 22;

   localparam int CODE_WORD_W = 32;
   localparam int CARRIER_W   = 9;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CARRIER_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CARRIER_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HDR_MARK       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HDR_SPACE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_MARK       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_SPACE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_SPACE     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRAILER_MARK   = 3'd7;

   // reset values
   localparam int CARRIER_PERIOD_RST = 378;
   localparam int CARRIER_HIGH_RST   = 126;
   localparam int HDR_MARK_RST       = 129600;
   localparam int HDR_SPACE_RST      = 64800;
   localparam int BIT_MARK_RST       = 8064;
   localparam int ONE_SPACE_RST      = 24192;
   localparam int ZERO_SPACE_RST     = 8064;
   localparam int TRAILER_MARK_RST   = 2880000;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_HMARK   = 6'b000010,
      PH_HSPACE  = 6'b000100,
      PH_BMARK   = 6'b001000,
      PH_BSPACE  = 6'b010000,
      PH_TRAILER = 6'b100000
   } phase_type;

   typedef struct packed {
      logic ir_out;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

// ===== sv/ir_pdt_if.sv =====
// ir_pdt_if: valid/ready channel interfaces for the request and result items.
// Depends on ir_pdt_pkg for the fixed code word width.

interface ir_pdt_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic [ir_pdt_pkg::CODE_WORD_W-1:0] code_word;

   modport source (output valid, output mode, output code_word, input ready);
   modport sink   (input valid, input mode, input code_word, output ready);
endinterface

interface ir_pdt_rsp_if;
   logic valid;
   logic ready;
   logic ir_out;
   logic busy_res;
   logic frame_done;

   modport source (output valid, output ir_out, output busy_res, output frame_done,
                   input ready);
   modport sink   (input valid, input ir_out, input busy_res, input frame_done,
                   output ready);
endinterface

// ===== sv/ir_pdt_csr.sv =====
// ir_pdt_csr: configuration register file for carrier and phase timing.
// Depends on ir_pdt_pkg for register indexes and reset values.

module ir_pdt_csr #(
   parameter int DURATION_BITS = ir_pdt_pkg::DURATION_BITS_DEF,
   parameter int CSR_W         = DURATION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ir_pdt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]                   csr_wdata,
   output logic [ir_pdt_pkg::CARRIER_W-1:0]   carrier_period,
   output logic [ir_pdt_pkg::CARRIER_W-1:0]   carrier_high,
   output logic [DURATION_BITS-1:0]           header_mark_ticks,
   output logic [DURATION_BITS-1:0]           header_space_ticks,
   output logic [DURATION_BITS-1:0]           bit_mark_ticks,
   output logic [DURATION_BITS-1:0]           one_space_ticks,
   output logic [DURATION_BITS-1:0]           zero_space_ticks,
   output logic [DURATION_BITS-1:0]           trailer_mark_ticks
);

   localparam int CW = ir_pdt_pkg::CARRIER_W;

   logic [CW-1:0]            period_ff, high_ff;
   logic [DURATION_BITS-1:0] hmark_ff, hspace_ff, bmark_ff, one_ff, zero_ff, trail_ff;
   logic [CW-1:0]            v_carrier;
   logic [DURATION_BITS-1:0] v_dur;

   assign v_carrier = csr_wdata[CW-1:0];
   assign v_dur     = csr_wdata[DURATION_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= CW'(ir_pdt_pkg::CARRIER_PERIOD_RST);
         high_ff   <= CW'(ir_pdt_pkg::CARRIER_HIGH_RST);
         hmark_ff  <= DURATION_BITS'(ir_pdt_pkg::HDR_MARK_RST);
         hspace_ff <= DURATION_BITS'(ir_pdt_pkg::HDR_SPACE_RST);
         bmark_ff  <= DURATION_BITS'(ir_pdt_pkg::BIT_MARK_RST);
         one_ff    <= DURATION_BITS'(ir_pdt_pkg::ONE_SPACE_RST);
         zero_ff   <= DURATION_BITS'(ir_pdt_pkg::ZERO_SPACE_RST);
         trail_ff  <= DURATION_BITS'(ir_pdt_pkg::TRAILER_MARK_RST);
      end else if (csr_we) begin
         case (csr_index)
            ir_pdt_pkg::REG_CARRIER_PERIOD: period_ff <= v_carrier;
            ir_pdt_pkg::REG_CARRIER_HIGH:   high_ff   <= v_carrier;
            ir_pdt_pkg::REG_HDR_MARK:       hmark_ff  <= v_dur;
            ir_pdt_pkg::REG_HDR_SPACE:      hspace_ff <= v_dur;
            ir_pdt_pkg::REG_BIT_MARK:       bmark_ff  <= v_dur;
            ir_pdt_pkg::REG_ONE_SPACE:      one_ff    <= v_dur;
            ir_pdt_pkg::REG_ZERO_SPACE:     zero_ff   <= v_dur;
            ir_pdt_pkg::REG_TRAILER_MARK:   trail_ff  <= v_dur;
            default: ;
         endcase
      end
   end

   assign carrier_period     = period_ff;
   assign carrier_high       = high_ff;
   assign header_mark_ticks  = hmark_ff;
   assign header_space_ticks = hspace_ff;
   assign bit_mark_ticks     = bmark_ff;
   assign one_space_ticks    = one_ff;
   assign zero_space_ticks   = zero_ff;
   assign trailer_mark_ticks = trail_ff;

endmodule

// ===== sv/ir_pdt_core.sv =====
// ir_pdt_core: frame sequencer, phase and carrier counters, and result logic.
// Depends on ir_pdt_pkg for the phase and result types.

module ir_pdt_core #(
   parameter int CODE_BITS     = ir_pdt_pkg::CODE_BITS_DEF,
   parameter int DURATION_BITS = ir_pdt_pkg::DURATION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic                               mode,
   input  logic [ir_pdt_pkg::CODE_WORD_W-1:0] code_word,
   input  logic [ir_pdt_pkg::CARRIER_W-1:0]   carrier_period,
   input  logic [ir_pdt_pkg::CARRIER_W-1:0]   carrier_high,
   input  logic [DURATION_BITS-1:0]           header_mark_ticks,
   input  logic [DURATION_BITS-1:0]           header_space_ticks,
   input  logic [DURATION_BITS-1:0]           bit_mark_ticks,
   input  logic [DURATION_BITS-1:0]           one_space_ticks,
   input  logic [DURATION_BITS-1:0]           zero_space_ticks,
   input  logic [DURATION_BITS-1:0]           trailer_mark_ticks,
   output ir_pdt_pkg::rsp_type                result
);

   localparam int CW     = ir_pdt_pkg::CARRIER_W;
   localparam int LEFT_W = $clog2(CODE_BITS + 1);

   ir_pdt_pkg::phase_type    phase_ff, phase_in;
   logic [DURATION_BITS-1:0] pc_ff, pc_in;
   logic [CW-1:0]            cc_ff, cc_in;
   logic [CODE_BITS-1:0]     bits_ff, bits_in;
   logic [LEFT_W-1:0]        left_ff, left_in;

   logic                     in_mark, level, busy, phase_end;
   logic [DURATION_BITS-1:0] len_raw, len;
   logic [LEFT_W-1:0]        left_dec;

   assign in_mark = (phase_ff == ir_pdt_pkg::PH_HMARK) ||
                    (phase_ff == ir_pdt_pkg::PH_BMARK) ||
                    (phase_ff == ir_pdt_pkg::PH_TRAILER);
   assign level   = in_mark && (cc_ff < carrier_high);
   assign busy    = (phase_ff != ir_pdt_pkg::PH_IDLE);

   always_comb begin
      case (phase_ff)
         ir_pdt_pkg::PH_HMARK:  len_raw = header_mark_ticks;
         ir_pdt_pkg::PH_HSPACE: len_raw = header_space_ticks;
         ir_pdt_pkg::PH_BMARK:  len_raw = bit_mark_ticks;
         ir_pdt_pkg::PH_BSPACE: len_raw = bits_ff[CODE_BITS-1] ? one_space_ticks
                                                                : zero_space_ticks;
         default:               len_raw = trailer_mark_ticks;
      endcase
   end

   assign len       = (len_raw == '0) ? DURATION_BITS'(1) : len_raw;
   assign phase_end = ({1'b0, pc_ff} + (DURATION_BITS + 1)'(1)) >= {1'b0, len};
   assign left_dec  = (left_ff != '0) ? left_ff - LEFT_W'(1) : '0;

   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      cc_in    = cc_ff;
      bits_in  = bits_ff;
      left_in  = left_ff;
      result.ir_out     = level;
      result.busy_res   = busy;
      result.frame_done = 1'b0;
      if (mode) begin
         if (!busy) begin
            // start of frame: first tick drives the header mark
            bits_in  = CODE_BITS'(code_word);
            left_in  = LEFT_W'(CODE_BITS);
            phase_in = ir_pdt_pkg::PH_HMARK;
            pc_in    = '0;
            cc_in    = '0;
            result.ir_out   = (carrier_high != '0);
            result.busy_res = 1'b1;
         end
      end else if (busy) begin
         if (in_mark) begin
            cc_in = (cc_ff >= carrier_period) ? '0 : cc_ff + CW'(1);
         end
         if (phase_end) begin
            pc_in = '0;
            cc_in = '0;
            case (phase_ff)
               ir_pdt_pkg::PH_HMARK:  phase_in = ir_pdt_pkg::PH_HSPACE;
               ir_pdt_pkg::PH_HSPACE: phase_in = ir_pdt_pkg::PH_BMARK;
               ir_pdt_pkg::PH_BMARK:  phase_in = ir_pdt_pkg::PH_BSPACE;
               ir_pdt_pkg::PH_BSPACE: begin
                  bits_in  = bits_ff << 1;
                  left_in  = left_dec;
                  phase_in = (left_dec == '0) ? ir_pdt_pkg::PH_TRAILER
                                              : ir_pdt_pkg::PH_BMARK;
               end
               default: begin
                  phase_in = ir_pdt_pkg::PH_IDLE;
                  result.frame_done = 1'b1;
               end
            endcase
         end else begin
            pc_in = pc_ff + DURATION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ir_pdt_pkg::PH_IDLE;
         pc_ff    <= '0;
         cc_ff    <= '0;
         bits_ff  <= '0;
         left_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         cc_ff    <= cc_in;
         bits_ff  <= bits_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== sv/ir_pulse_distance_transmitter.sv =====
// ir_pulse_distance_transmitter: input register, frame core and result register;
// depends on ir_pdt_pkg, ir_pdt_if, ir_pdt_csr and ir_pdt_core.
// An item is held in the input register and its result in the result register.
// Throughput: one item per cycle while the result is taken; the input and result
// registers form a two-stage pipe, so a new item is taken while a result waits.
// Reset (synchronous, active high) empties the pipe, idles the frame, reloads timing.

module ir_pulse_distance_transmitter #(
   parameter int CODE_BITS     = ir_pdt_pkg::CODE_BITS_DEF,
   parameter int DURATION_BITS = ir_pdt_pkg::DURATION_BITS_DEF,
   parameter int CSR_W         = (DURATION_BITS > ir_pdt_pkg::CARRIER_W) ?
                                 DURATION_BITS : ir_pdt_pkg::CARRIER_W
) (
   input  logic                               clock,
   input  logic                               reset,
   ir_pdt_req_if.sink                         req_ch,
   ir_pdt_rsp_if.source                       rsp_ch,
   input  logic                               csr_we,
   input  logic [ir_pdt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]                   csr_wdata
);

   localparam int CW = ir_pdt_pkg::CARRIER_W;

   logic                               in_valid_ff;
   logic                               in_mode_ff;
   logic [ir_pdt_pkg::CODE_WORD_W-1:0] in_code_ff;
   logic                               out_valid_ff;
   ir_pdt_pkg::rsp_type                out_data_ff, core_res;
   logic                               advance, take;

   logic [CW-1:0]            carrier_period, carrier_high;
   logic [DURATION_BITS-1:0] header_mark_ticks, header_space_ticks, bit_mark_ticks;
   logic [DURATION_BITS-1:0] one_space_ticks, zero_space_ticks, trailer_mark_ticks;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req_ch.mode;
         in_code_ff <= req_ch.code_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_res;
      end
   end

   ir_pdt_csr #(
      .DURATION_BITS (DURATION_BITS),
      .CSR_W         (CSR_W)
   ) u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .carrier_period     (carrier_period),
      .carrier_high       (carrier_high),
      .header_mark_ticks  (header_mark_ticks),
      .header_space_ticks (header_space_ticks),
      .bit_mark_ticks     (bit_mark_ticks),
      .one_space_ticks    (one_space_ticks),
      .zero_space_ticks   (zero_space_ticks),
      .trailer_mark_ticks (trailer_mark_ticks)
   );

   ir_pdt_core #(
      .CODE_BITS     (CODE_BITS),
      .DURATION_BITS (DURATION_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .fire               (advance),
      .mode               (in_mode_ff),
      .code_word          (in_code_ff),
      .carrier_period     (carrier_period),
      .carrier_high       (carrier_high),
      .header_mark_ticks  (header_mark_ticks),
      .header_space_ticks (header_space_ticks),
      .bit_mark_ticks     (bit_mark_ticks),
      .one_space_ticks    (one_space_ticks),
      .zero_space_ticks   (zero_space_ticks),
      .trailer_mark_ticks (trailer_mark_ticks),
      .result             (core_res)
   );

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.ir_out     = out_data_ff.ir_out;
   assign rsp_ch.busy_res   = out_data_ff.busy_res;
   assign rsp_ch.frame_done = out_data_ff.frame_done;

endmodule

// ===== sv/ir_pdt_checker.sv =====
// ir_pdt_checker: port-level assertions for the transmitter, bound to the top.
// Depends only on the top level's ports.

module ir_pdt_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic ir_out,
   input logic busy_res,
   input logic frame_done
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // emitter lit only inside a frame
   a_ir_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ir_out |-> busy_res)
      else $error("ir_out high while idle");

   // frame end reported only while busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> busy_res)
      else $error("frame_done without busy");

   // pipe empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ir_pulse_distance_transmitter ir_pdt_checker u_ir_pdt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .ir_out     (rsp_ch.ir_out),
   .busy_res   (rsp_ch.busy_res),
   .frame_done (rsp_ch.frame_done)
);

// ===== bench/ir_pulse_distance_transmitter_check.sv =====
// Checker for the pulse-distance infrared transmitter: watches the request,
// result and register write ports, predicts every result and compares.
// Depends on ir_pdt_pkg and ir_pdt_if.

module ir_pulse_distance_transmitter_check
   import ir_pdt_pkg::*;
#(
   parameter int CSR_W = DURATION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ir_pdt_req_if                  req_ch,
   ir_pdt_rsp_if                  rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     pending_count,
   output logic                   frame_busy,
   output int                     frames_finished
);

   logic [CARRIER_W-1:0]         period_q;
   logic [CARRIER_W-1:0]         high_q;
   logic [DURATION_BITS_DEF-1:0] hdr_mark_q;
   logic [DURATION_BITS_DEF-1:0] hdr_space_q;
   logic [DURATION_BITS_DEF-1:0] bit_mark_q;
   logic [DURATION_BITS_DEF-1:0] one_space_q;
   logic [DURATION_BITS_DEF-1:0] zero_space_q;
   logic [DURATION_BITS_DEF-1:0] trailer_q;

   phase_type                    phase_q;
   logic [DURATION_BITS_DEF-1:0] phase_cnt;
   logic [CARRIER_W-1:0]         carrier_cnt;
   logic [CODE_WORD_W-1:0]       code_shift;
   logic [5:0]                   bits_left;

   rsp_type expected_levels[$];
   int      mismatches;
   int      frames;
   int      results_seen;

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      frame_busy      = 1'b0;
      frames_finished = 0;
      mismatches      = 0;
      frames          = 0;
      results_seen    = 0;
   end

   function automatic logic in_mark();
      return phase_q == PH_HMARK || phase_q == PH_BMARK || phase_q == PH_TRAILER;
   endfunction

   function automatic logic emitter_level();
      return in_mark() && (carrier_cnt < high_q);
   endfunction

   function automatic int unsigned phase_ticks();
      logic [DURATION_BITS_DEF-1:0] d;
      case (phase_q)
         PH_HMARK:  d = hdr_mark_q;
         PH_HSPACE: d = hdr_space_q;
         PH_BMARK:  d = bit_mark_q;
         PH_BSPACE: d = code_shift[CODE_WORD_W-1] ? one_space_q : zero_space_q;
         default:   d = trailer_q;
      endcase
      return (d == '0) ? 1 : int'(d);
   endfunction

   function automatic rsp_type advance_transmitter(logic mode, logic [CODE_WORD_W-1:0] code);
      rsp_type     r;
      int unsigned len;
      r.frame_done = 1'b0;
      if (mode) begin
         if (phase_q == PH_IDLE) begin
            code_shift  = code;
            bits_left   = 6'(CODE_BITS_DEF);
            phase_q     = PH_HMARK;
            phase_cnt   = '0;
            carrier_cnt = '0;
         end
         r.ir_out   = emitter_level();
         r.busy_res = (phase_q != PH_IDLE);
         return r;
      end
      r.ir_out   = emitter_level();
      r.busy_res = (phase_q != PH_IDLE);
      if (phase_q != PH_IDLE) begin
         len = phase_ticks();
         if (in_mark()) begin
            carrier_cnt = (carrier_cnt >= period_q) ? '0 : carrier_cnt + 1'b1;
         end
         if (int'(phase_cnt) + 1 >= len) begin
            phase_cnt   = '0;
            carrier_cnt = '0;
            case (phase_q)
               PH_HMARK:  phase_q = PH_HSPACE;
               PH_HSPACE: phase_q = PH_BMARK;
               PH_BMARK:  phase_q = PH_BSPACE;
               PH_BSPACE: begin
                  code_shift = code_shift << 1;
                  if (bits_left != 0) bits_left = bits_left - 1'b1;
                  if (bits_left == 0) begin
                     phase_q = PH_TRAILER;
                  end else begin
                     phase_q = PH_BMARK;
                  end
               end
               default: begin
                  phase_q      = PH_IDLE;
                  r.frame_done = 1'b1;
               end
            endcase
         end else begin
            phase_cnt = phase_cnt + 1'b1;
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(string field, logic want, logic got);
      if (mismatches < 10) begin
         $display("mismatch in %s of result %0d: expected %b, got %b",
                  field, results_seen, want, got);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         period_q     = CARRIER_W'(CARRIER_PERIOD_RST);
         high_q       = CARRIER_W'(CARRIER_HIGH_RST);
         hdr_mark_q   = DURATION_BITS_DEF'(HDR_MARK_RST);
         hdr_space_q  = DURATION_BITS_DEF'(HDR_SPACE_RST);
         bit_mark_q   = DURATION_BITS_DEF'(BIT_MARK_RST);
         one_space_q  = DURATION_BITS_DEF'(ONE_SPACE_RST);
         zero_space_q = DURATION_BITS_DEF'(ZERO_SPACE_RST);
         trailer_q    = DURATION_BITS_DEF'(TRAILER_MARK_RST);
         phase_q      = PH_IDLE;
         phase_cnt    = '0;
         carrier_cnt  = '0;
         code_shift   = '0;
         bits_left    = '0;
         expected_levels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CARRIER_PERIOD: period_q     = csr_wdata[CARRIER_W-1:0];
               REG_CARRIER_HIGH:   high_q       = csr_wdata[CARRIER_W-1:0];
               REG_HDR_MARK:       hdr_mark_q   = csr_wdata[DURATION_BITS_DEF-1:0];
               REG_HDR_SPACE:      hdr_space_q  = csr_wdata[DURATION_BITS_DEF-1:0];
               REG_BIT_MARK:       bit_mark_q   = csr_wdata[DURATION_BITS_DEF-1:0];
               REG_ONE_SPACE:      one_space_q  = csr_wdata[DURATION_BITS_DEF-1:0];
               REG_ZERO_SPACE:     zero_space_q = csr_wdata[DURATION_BITS_DEF-1:0];
               REG_TRAILER_MARK:   trailer_q    = csr_wdata[DURATION_BITS_DEF-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_levels.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result %0d: ir_out %b busy_res %b frame_done %b",
                           results_seen, rsp_ch.ir_out, rsp_ch.busy_res, rsp_ch.frame_done);
               end
               mismatches++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_ch.ir_out !== want.ir_out)
                  flag_mismatch("ir_out", want.ir_out, rsp_ch.ir_out);
               if (rsp_ch.busy_res !== want.busy_res)
                  flag_mismatch("busy_res", want.busy_res, rsp_ch.busy_res);
               if (rsp_ch.frame_done !== want.frame_done)
                  flag_mismatch("frame_done", want.frame_done, rsp_ch.frame_done);
            end
            results_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            want = advance_transmitter(req_ch.mode, req_ch.code_word);
            if (want.frame_done) frames++;
            expected_levels.push_back(want);
         end
      end
      mismatch_count  <= mismatches;
      pending_count   <= expected_levels.size();
      frame_busy      <= (phase_q != PH_IDLE);
      frames_finished <= frames;
   end

endmodule

// ===== bench/ir_pulse_distance_transmitter_test.sv =====
// Top of the pulse-distance infrared transmitter bench: clock, reset, timing
// register writes, request traffic and receiver stalls, plus the verdict.
// Depends on ir_pdt_pkg, ir_pdt_if, the transmitter and its checker.

module ir_pulse_distance_transmitter_test;
   import ir_pdt_pkg::*;

   localparam int CSR_W = (DURATION_BITS_DEF > CARRIER_W) ? DURATION_BITS_DEF : CARRIER_W;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [CSR_W-1:0] DUR_MAX = '1;

   typedef enum int {CODES_ANY, CODES_ZERO, CODES_ONES} code_mix_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   int   mismatch_count;
   int   pending_count;
   logic frame_busy;
   int   frames_finished;

   int burst_left;
   int ticks_sent;
   int sends_sent;
   int settings_used;
   int hold_asked;

   ir_pdt_req_if req_ch();
   ir_pdt_rsp_if rsp_ch();

   ir_pulse_distance_transmitter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ir_pulse_distance_transmitter_check #(.CSR_W(CSR_W)) i_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .frame_busy      (frame_busy),
      .frames_finished (frames_finished)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ir_pulse_distance_transmitter_test NOT OK");
      $finish;
   end

   // receiver: stall pattern that changes now and then, plus long hold-offs
   initial begin
      int       hold_seen;
      int       hold_left;
      int       pattern_age;
      int       pos;
      bit [7:0] stall_mask;
      hold_seen   = 0;
      hold_left   = 0;
      pattern_age = 0;
      pos         = 0;
      stall_mask  = '1;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 250;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               pattern_age = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: stall_mask = '1;
                  1: stall_mask = 8'($urandom()) | 8'h01;
                  2: stall_mask = 8'($urandom()) & 8'($urandom()) | 8'h10;
                  default: stall_mask = 8'($urandom()) | 8'($urandom());
               endcase
            end
            pattern_age--;
            pos = (pos + 1) % 8;
            rsp_ch.ready <= stall_mask[pos];
         end
      end
   end

   function automatic logic [CODE_WORD_W-1:0] pick_code(code_mix_type mix);
      case (mix)
         CODES_ZERO: return '0;
         CODES_ONES: return '1;
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return '1;
               2: return CODE_WORD_W'(1) << $urandom_range(0, CODE_WORD_W - 1);
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [CSR_W-1:0] period_w, logic [CSR_W-1:0] high_w,
                                 logic [CSR_W-1:0] hdr_mark, logic [CSR_W-1:0] hdr_space,
                                 logic [CSR_W-1:0] bit_mark, logic [CSR_W-1:0] one_space,
                                 logic [CSR_W-1:0] zero_space, logic [CSR_W-1:0] trailer,
                                 bit with_carrier);
      if (with_carrier) begin
         csr_write(REG_CARRIER_PERIOD, period_w);
         csr_write(REG_CARRIER_HIGH, high_w);
      end
      csr_write(REG_HDR_MARK, hdr_mark);
      csr_write(REG_HDR_SPACE, hdr_space);
      csr_write(REG_BIT_MARK, bit_mark);
      csr_write(REG_ONE_SPACE, one_space);
      csr_write(REG_ZERO_SPACE, zero_space);
      csr_write(REG_TRAILER_MARK, trailer);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // called at a rising edge, returns at the edge where the item is taken
   task automatic send_item(logic mode, logic [CODE_WORD_W-1:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.code_word <= code;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // tick until the frame is over and every result is back
   task automatic settle_frame();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (frame_busy) begin
         send_item(1'b0, $urandom());
         ticks_sent++;
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic drive_phase(int tick_quota, code_mix_type mix, bit with_hold);
      int done_ticks;
      if (with_hold) hold_asked <= hold_asked + 1;
      done_ticks = 0;
      while (done_ticks < tick_quota) begin
         if ($urandom_range(0, 99) < (frame_busy ? 2 : 30)) begin
            send_item(1'b1, pick_code(mix));
            sends_sent++;
         end else begin
            send_item(1'b0, $urandom());
            done_ticks++;
            ticks_sent++;
         end
      end
      settle_frame();
   endtask

   initial begin
      logic [CARRIER_W-1:0] period_v;
      logic [CARRIER_W-1:0] high_v;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= REG_CARRIER_PERIOD;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= 1'b0;
      req_ch.code_word <= '0;
      hold_asked       <= 0;
      burst_left    = 0;
      ticks_sent    = 0;
      sends_sent    = 0;
      settings_used = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // carrier at its reset timing, header mark long enough for the carrier to drop
      apply_settings('0, '0, 140, 0, 1, 2, 1, 3, 1'b0);
      send_item(1'b0, 32'h0000_0000);
      send_item(1'b1, 32'hFFFF_FFFF);
      send_item(1'b1, 32'h1234_5678);
      send_item(1'b0, 32'hFFFF_FFFF);
      settle_frame();
      send_item(1'b1, 32'h0000_0000);
      settle_frame();
      send_item(1'b1, 32'h8000_0001);
      send_item(1'b1, 32'h7FFF_FFFE);
      settle_frame();
      sends_sent += 5;
      ticks_sent += 2;

      // zero period and zero lengths
      apply_settings(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
      drive_phase(20, CODES_ANY, 1'b0);
      apply_settings(0, 1, 1, 1, 1, 1, 1, 1, 1'b1);
      drive_phase(20, CODES_ANY, 1'b0);
      apply_settings(511, 511, 3, 1, 2, 3, 1, 2, 1'b1);
      drive_phase(20, CODES_ANY, 1'b1);
      // high count above the period
      apply_settings(1, 5, 6, 2, 2, 2, 1, 4, 1'b1);
      drive_phase(20, CODES_ANY, 1'b0);
      // longest spaces, kept out of the way by the code words
      apply_settings(3, 2, 5, 1, 1, DUR_MAX, 1, 5, 1'b1);
      drive_phase(20, CODES_ZERO, 1'b0);
      apply_settings(2, 1, 5, 1, 1, 1, DUR_MAX, 5, 1'b1);
      drive_phase(20, CODES_ONES, 1'b0);
      apply_settings(1, 0, 4, 2, 1, 2, 0, 3, 1'b1);
      drive_phase(20, CODES_ANY, 1'b0);

      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 3))
            0: period_v = CARRIER_W'($urandom_range(0, 3));
            1: period_v = CARRIER_W'($urandom_range(4, 20));
            2: period_v = 9'd511;
            default: period_v = CARRIER_W'($urandom_range(0, 511));
         endcase
         case ($urandom_range(0, 3))
            0: high_v = '0;
            1: high_v = 9'd511;
            default: high_v = CARRIER_W'($urandom_range(0, int'(period_v) + 1));
         endcase
         apply_settings({13'($urandom()), period_v}, {13'($urandom()), high_v},
                        CSR_W'($urandom_range(0, 40)), CSR_W'($urandom_range(0, 3)),
                        CSR_W'($urandom_range(0, 3)), CSR_W'($urandom_range(0, 3)),
                        CSR_W'($urandom_range(0, 3)), CSR_W'($urandom_range(0, 40)), 1'b1);
         drive_phase(20, CODES_ANY, k == 2);
      end

      $display("covered %0d timer ticks and %0d send requests over %0d timing settings",
               ticks_sent, sends_sent, settings_used);
      $display("%0d frames finished, long receiver hold-offs included", frames_finished);
      if (mismatch_count == 0) begin
         $display("ir_pulse_distance_transmitter_test OK");
      end else begin
         $display("ir_pulse_distance_transmitter_test NOT OK");
      end
      $finish;
   end

endmodule
